// ===== rtl/core/bpq_pkg.sv =====
// Shared types, widths and codes for the block pool queue manager.
// No dependencies; every other file of the block but bpq_ram uses this package.
package bpq_pkg;

    // Pool geometry
    localparam int NUM_BLOCKS = 256;
    localparam int BLK_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

    // Field widths
    localparam int CMD_W      = 2;
    localparam int SIZE_W     = 16;
    localparam int IDX_W      = 8;
    localparam int STAT_W     = 3;
    localparam int QCNT_W     = 9;
    localparam int BCNT_W     = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int QCNT_MAX   = (1 << QCNT_W) - 1;

    // Register reset values
    localparam logic [SIZE_W-1:0] MAX_SIZE_RST = SIZE_W'(4096);
    localparam logic [BCNT_W-1:0] BCNT_RST     = BCNT_W'(256);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BLK_COUNT = CFG_IDX_W'(1);

    // Commands
    localparam logic [CMD_W-1:0] CMD_ADD  = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_GET  = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_FREE = CMD_W'(2);

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK          = STAT_W'(0);
    localparam logic [STAT_W-1:0] ST_BAD_SIZE    = STAT_W'(1);
    localparam logic [STAT_W-1:0] ST_FULL        = STAT_W'(2);
    localparam logic [STAT_W-1:0] ST_EMPTY       = STAT_W'(3);
    localparam logic [STAT_W-1:0] ST_INDEX_OUT   = STAT_W'(4);
    localparam logic [STAT_W-1:0] ST_NOT_PENDING = STAT_W'(5);
    localparam logic [STAT_W-1:0] ST_BAD_BLOCK   = STAT_W'(6);

    // Controller to datapath commands
    typedef struct packed {
        logic clear;  // write one entry of the clearing pass
        logic load;   // capture the accepted beat and launch RAM reads
        logic exec;   // update the pool and load the result register
    } t_dp_cmd;

endpackage

// ===== rtl/core/bpq_in_if.sv =====
// Request channel of the block pool queue manager: valid/ready plus command payload.
// Depends on bpq_pkg for field widths.
interface bpq_in_if;
    logic                         valid;
    logic                         ready;
    logic [bpq_pkg::CMD_W-1:0]    cmd;
    logic [bpq_pkg::SIZE_W-1:0]   data_size;
    logic [bpq_pkg::IDX_W-1:0]    block_index;

    modport source (output valid, cmd, data_size, block_index, input ready);
    modport sink   (input valid, cmd, data_size, block_index, output ready);
endinterface

// ===== rtl/core/bpq_out_if.sv =====
// Result channel of the block pool queue manager: valid/ready plus result payload.
// Depends on bpq_pkg for field widths.
interface bpq_out_if;
    logic                         valid;
    logic                         ready;
    logic [bpq_pkg::STAT_W-1:0]   status;
    logic [bpq_pkg::IDX_W-1:0]    out_block_index;
    logic [bpq_pkg::SIZE_W-1:0]   out_data_size;
    logic [bpq_pkg::QCNT_W-1:0]   queue_count;

    modport source (output valid, status, out_block_index, out_data_size, queue_count,
                    input ready);
    modport sink   (input valid, status, out_block_index, out_data_size, queue_count,
                    output ready);
endinterface

// ===== rtl/core/bpq_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module bpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/bpq_ctrl.sv =====
// Controller of the block pool queue manager: clear/idle/execute sequencer and result-valid flag.
// Depends on bpq_pkg for the datapath command struct.
module bpq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic              i_reinit,
    input  logic              i_clr_last,
    output bpq_pkg::t_dp_cmd  o_cmd
);
    import bpq_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic accept;
    logic exec;
    logic clear;

    // Take a beat only when idle; execute once the result register is free
    assign accept = (r_state == S_IDLE) && i_in_valid;
    assign exec   = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign clear  = (r_state == S_CLEAR);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (exec) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
        // Restart the clearing pass on a block-count write
        if (i_reinit) n_state = S_CLEAR;
    end

    // Hold the result until taken, load a new one on execute
    assign n_out_valid = exec || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd.clear = clear;
    assign o_cmd.load  = accept;
    assign o_cmd.exec  = exec;
endmodule

// ===== rtl/core/bpq_dp.sv =====
// Datapath of the block pool queue manager: config registers, free list, ready queue,
// pending set and result register. Depends on bpq_pkg and bpq_ram.
module bpq_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bpq_pkg::t_dp_cmd                  i_cmd,
    input  logic [bpq_pkg::CMD_W-1:0]         i_op,
    input  logic [bpq_pkg::SIZE_W-1:0]        i_data_size,
    input  logic [bpq_pkg::IDX_W-1:0]         i_block_index,
    input  logic                              i_cfg_we,
    input  logic [bpq_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bpq_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_reinit,
    output logic                              o_clr_last,
    output logic [bpq_pkg::STAT_W-1:0]        o_status,
    output logic [bpq_pkg::IDX_W-1:0]         o_block_index,
    output logic [bpq_pkg::SIZE_W-1:0]        o_data_size,
    output logic [bpq_pkg::QCNT_W-1:0]        o_queue_count
);
    import bpq_pkg::*;

    localparam int RDY_W = BLK_W + SIZE_W;

    // Clamp a block count to the pool size
    function automatic logic [CNT_W-1:0] eff_count(input logic [BCNT_W-1:0] bcnt);
        if (32'(bcnt) > NUM_BLOCKS) return CNT_W'(NUM_BLOCKS);
        return CNT_W'(bcnt);
    endfunction

    // Advance a ring pointer
    function automatic logic [BLK_W-1:0] ptr_inc(input logic [BLK_W-1:0] p);
        if (32'(p) == NUM_BLOCKS - 1) return '0;
        return p + BLK_W'(1);
    endfunction

    // Tail of a freshly filled free list
    function automatic logic [BLK_W-1:0] fill_tail(input logic [CNT_W-1:0] cnt);
        if (32'(cnt) == NUM_BLOCKS) return '0;
        return BLK_W'(cnt);
    endfunction

    // Configuration
    logic [SIZE_W-1:0] r_max_size;
    logic [BCNT_W-1:0] r_blk_cnt;
    logic [CNT_W-1:0]  eff_cnt;
    logic [CNT_W-1:0]  cfg_eff;

    // Captured beat
    logic [CMD_W-1:0]  r_op;
    logic [SIZE_W-1:0] r_size;
    logic [IDX_W-1:0]  r_idx;

    // Clearing pass address
    logic [BLK_W-1:0]  r_clr_addr;

    // Free list: the clearing pass loads every entry with its own index
    logic [BLK_W-1:0]  r_free_head, n_free_head;
    logic [BLK_W-1:0]  r_free_tail, n_free_tail;
    logic [CNT_W-1:0]  r_free_cnt, n_free_cnt;
    logic [BLK_W-1:0]  free_blk;
    logic              free_we;
    logic [BLK_W-1:0]  free_wdata;
    logic              free_ram_we;
    logic [BLK_W-1:0]  free_ram_waddr;
    logic [BLK_W-1:0]  free_ram_wdata;

    // Ready queue: each entry carries the block and its size
    logic [BLK_W-1:0]  r_rdy_head, n_rdy_head;
    logic [BLK_W-1:0]  r_rdy_tail, n_rdy_tail;
    logic [CNT_W-1:0]  r_rdy_cnt, n_rdy_cnt;
    logic [RDY_W-1:0]  rdy_q;
    logic [BLK_W-1:0]  rdy_blk;
    logic [SIZE_W-1:0] rdy_size;
    logic              rdy_we;
    logic [RDY_W-1:0]  rdy_wdata;

    // Pending set: one bit per block in RAM, read at the beat's block index
    logic              pend_q;
    logic              pend_set;
    logic              pend_clr;
    logic [BLK_W-1:0]  pend_blk;
    logic [BLK_W-1:0]  pend_raddr;
    logic              pend_ram_we;
    logic [BLK_W-1:0]  pend_ram_waddr;
    logic              pend_ram_wdata;
    logic [BLK_W-1:0]  idx_blk;
    logic              cfg_reinit;

    // Result
    logic [STAT_W-1:0] r_status, n_status;
    logic [IDX_W-1:0]  r_oidx, n_oidx;
    logic [SIZE_W-1:0] r_osize, n_osize;
    logic [QCNT_W-1:0] r_qcnt, n_qcnt;

    assign eff_cnt    = eff_count(r_blk_cnt);
    assign cfg_eff    = eff_count(i_cfg_data[BCNT_W-1:0]);
    assign cfg_reinit = i_cfg_we && (i_cfg_idx == CFG_BLK_COUNT);
    assign o_reinit   = cfg_reinit;
    assign o_clr_last = (32'(r_clr_addr) == NUM_BLOCKS - 1);

    // The clearing pass owns the write ports while it runs
    assign free_ram_we    = i_cmd.clear || (i_cmd.exec && free_we);
    assign free_ram_waddr = i_cmd.clear ? r_clr_addr : r_free_tail;
    assign free_ram_wdata = i_cmd.clear ? r_clr_addr : free_wdata;
    assign pend_ram_we    = i_cmd.clear || (i_cmd.exec && (pend_set || pend_clr));
    assign pend_ram_waddr = i_cmd.clear ? r_clr_addr : pend_blk;
    assign pend_ram_wdata = !i_cmd.clear && pend_set;
    assign pend_raddr     = BLK_W'(i_block_index);

    bpq_ram #(.WIDTH(BLK_W), .DEPTH(NUM_BLOCKS)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (free_ram_we),
        .i_waddr (free_ram_waddr),
        .i_wdata (free_ram_wdata),
        .i_re    (i_cmd.load),
        .i_raddr (r_free_head),
        .o_rdata (free_blk)
    );

    bpq_ram #(.WIDTH(RDY_W), .DEPTH(NUM_BLOCKS)) u_rdy_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && rdy_we),
        .i_waddr (r_rdy_tail),
        .i_wdata (rdy_wdata),
        .i_re    (i_cmd.load),
        .i_raddr (r_rdy_head),
        .o_rdata (rdy_q)
    );

    bpq_ram #(.WIDTH(1), .DEPTH(NUM_BLOCKS)) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (pend_ram_we),
        .i_waddr (pend_ram_waddr),
        .i_wdata (pend_ram_wdata),
        .i_re    (i_cmd.load),
        .i_raddr (pend_raddr),
        .o_rdata (pend_q)
    );

    assign rdy_blk  = rdy_q[RDY_W-1:SIZE_W];
    assign rdy_size = rdy_q[SIZE_W-1:0];
    assign idx_blk  = BLK_W'(r_idx);

    // Decode the captured command against the pool state
    always_comb begin
        n_free_head = r_free_head;
        n_free_tail = r_free_tail;
        n_free_cnt  = r_free_cnt;
        n_rdy_head  = r_rdy_head;
        n_rdy_tail  = r_rdy_tail;
        n_rdy_cnt   = r_rdy_cnt;
        n_status    = ST_OK;
        n_oidx      = '0;
        n_osize     = '0;
        free_we     = 1'b0;
        free_wdata  = idx_blk;
        rdy_we      = 1'b0;
        rdy_wdata   = {free_blk, r_size};
        pend_set    = 1'b0;
        pend_clr    = 1'b0;
        pend_blk    = idx_blk;
        case (r_op)
            CMD_ADD: begin
                if (r_size == '0 || r_size > r_max_size) begin
                    n_status = ST_BAD_SIZE;
                end else if (r_free_cnt == '0) begin
                    n_status = ST_FULL;
                end else begin
                    n_free_head = ptr_inc(r_free_head);
                    n_free_cnt  = r_free_cnt - CNT_W'(1);
                    n_oidx      = IDX_W'(free_blk);
                    if (32'(r_rdy_cnt) < NUM_BLOCKS) begin
                        rdy_we     = 1'b1;
                        n_rdy_tail = ptr_inc(r_rdy_tail);
                        n_rdy_cnt  = r_rdy_cnt + CNT_W'(1);
                    end
                end
            end
            CMD_GET: begin
                if (r_rdy_cnt == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_rdy_head = ptr_inc(r_rdy_head);
                    n_rdy_cnt  = r_rdy_cnt - CNT_W'(1);
                    n_oidx     = IDX_W'(rdy_blk);
                    pend_blk   = rdy_blk;
                    if (rdy_size != '0) begin
                        n_osize  = rdy_size;
                        pend_set = 1'b1;
                    end else begin
                        // Sizeless block: release it instead of handing it out
                        n_status   = ST_BAD_BLOCK;
                        pend_clr   = 1'b1;
                        free_we    = 1'b1;
                        free_wdata = rdy_blk;
                    end
                end
            end
            CMD_FREE: begin
                if (CNT_W'(r_idx) >= eff_cnt || 32'(r_idx) >= NUM_BLOCKS) begin
                    n_status = ST_INDEX_OUT;
                end else if (!pend_q) begin
                    n_status = ST_NOT_PENDING;
                end else begin
                    pend_clr = 1'b1;
                    free_we  = 1'b1;
                end
            end
            default: ;
        endcase
        // Drop a push into a full free list
        if (free_we) begin
            if (32'(r_free_cnt) < NUM_BLOCKS) begin
                n_free_tail = ptr_inc(r_free_tail);
                n_free_cnt  = r_free_cnt + CNT_W'(1);
            end else begin
                free_we = 1'b0;
            end
        end
        if (32'(n_rdy_cnt) > QCNT_MAX) n_qcnt = QCNT_W'(QCNT_MAX);
        else n_qcnt = QCNT_W'(n_rdy_cnt);
    end

    // Capture the beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_size <= i_data_size;
            r_idx  <= i_block_index;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_oidx   <= n_oidx;
            r_osize  <= n_osize;
            r_qcnt   <= n_qcnt;
        end
    end

    // Step the clearing pass; restart it on reset and block-count writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_reinit) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= ptr_inc(r_clr_addr);
        end
    end

    // Pool state: reset and block-count writes refill the free list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size  <= MAX_SIZE_RST;
            r_blk_cnt   <= BCNT_RST;
            r_free_head <= '0;
            r_free_tail <= fill_tail(eff_count(BCNT_RST));
            r_free_cnt  <= eff_count(BCNT_RST);
            r_rdy_head  <= '0;
            r_rdy_tail  <= '0;
            r_rdy_cnt   <= '0;
        end else if (cfg_reinit) begin
            r_blk_cnt   <= i_cfg_data[BCNT_W-1:0];
            r_free_head <= '0;
            r_free_tail <= fill_tail(cfg_eff);
            r_free_cnt  <= cfg_eff;
            r_rdy_head  <= '0;
            r_rdy_tail  <= '0;
            r_rdy_cnt   <= '0;
        end else if (i_cfg_we && i_cfg_idx == CFG_MAX_SIZE) begin
            r_max_size <= i_cfg_data[SIZE_W-1:0];
        end else if (i_cmd.exec) begin
            r_free_head <= n_free_head;
            r_free_tail <= n_free_tail;
            r_free_cnt  <= n_free_cnt;
            r_rdy_head  <= n_rdy_head;
            r_rdy_tail  <= n_rdy_tail;
            r_rdy_cnt   <= n_rdy_cnt;
        end
    end

    assign o_status      = r_status;
    assign o_block_index = r_oidx;
    assign o_data_size   = r_osize;
    assign o_queue_count = r_qcnt;
endmodule

// ===== rtl/core/block_pool_queue_manager_unit.sv =====
// Block pool queue manager: free list, ready queue and pending set over a pool of blocks.
// Depends on bpq_pkg, bpq_in_if, bpq_out_if, bpq_ctrl, bpq_dp and bpq_ram.
//
// Each request (add, get or free) runs in two steps: the registered reads of the free-list,
// ready-queue and pending-bit RAMs, then the update and the load of the result register,
// which waits until the result register is free. A new request is taken while the previous
// result still waits on the output, but not before the previous request has executed. One
// result beat leaves for every request. After reset and after every block_count write a
// clearing pass over every block loads the free-list RAM with indices 0 to 255 and clears
// the pending bits; no request is taken until it ends.
// Write configuration only while idle.
module block_pool_queue_manager_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bpq_in_if.sink                          in_ch,
    bpq_out_if.source                       out_ch,
    input  logic                            i_cfg_we,
    input  logic [bpq_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bpq_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bpq_pkg::*;

    t_dp_cmd dp_cmd;
    logic    dp_reinit;
    logic    dp_clr_last;

    bpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_reinit    (dp_reinit),
        .i_clr_last  (dp_clr_last),
        .o_cmd       (dp_cmd)
    );

    bpq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_op          (in_ch.cmd),
        .i_data_size   (in_ch.data_size),
        .i_block_index (in_ch.block_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_reinit      (dp_reinit),
        .o_clr_last    (dp_clr_last),
        .o_status      (out_ch.status),
        .o_block_index (out_ch.out_block_index),
        .o_data_size   (out_ch.out_data_size),
        .o_queue_count (out_ch.queue_count)
    );
endmodule

// ===== rtl/core/bpq_checker.sv =====
// Port-level checks for the block pool queue manager, bound to the top level.
// Depends on bpq_pkg for widths and status codes.
module bpq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [bpq_pkg::STAT_W-1:0]    i_status,
    input logic [bpq_pkg::IDX_W-1:0]     i_out_block_index,
    input logic [bpq_pkg::SIZE_W-1:0]    i_out_data_size,
    input logic [bpq_pkg::QCNT_W-1:0]    i_queue_count
);
    import bpq_pkg::*;

    // A stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_out_block_index) && $stable(i_out_data_size)
            && $stable(i_queue_count))
        else $error("result beat changed while stalled");

    // One request in flight: no beat taken right after another
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted while the previous one executes");

    // An empty report leaves an empty ready queue
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_EMPTY |-> i_queue_count == '0)
        else $error("empty status with nonzero queue count");

    // Rejected requests other than a bad block carry no block and no size
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_BAD_SIZE || i_status == ST_FULL
            || i_status == ST_EMPTY || i_status == ST_INDEX_OUT
            || i_status == ST_NOT_PENDING)
        |-> i_out_block_index == '0 && i_out_data_size == '0)
        else $error("rejected request returned block data");
endmodule

bind block_pool_queue_manager_unit bpq_checker u_bpq_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (in_ch.valid),
    .i_in_ready        (in_ch.ready),
    .i_out_valid       (out_ch.valid),
    .i_out_ready       (out_ch.ready),
    .i_status          (out_ch.status),
    .i_out_block_index (out_ch.out_block_index),
    .i_out_data_size   (out_ch.out_data_size),
    .i_queue_count     (out_ch.queue_count)
);

// ===== tb/sv/block_pool_queue_manager_unit_tb.sv =====
// Self-checking testbench for block_pool_queue_manager_unit: directed and random requests
// are checked beat by beat against a behavioral model of the pool kept here.
// Depends on bpq_pkg, bpq_in_if, bpq_out_if and the block's RTL.
module block_pool_queue_manager_unit_tb;
    import bpq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED     = CMD_W'(3);
    localparam int               HALF_PERIOD    = 6;
    localparam int               TIMEOUT_CYCLES = 400000;
    localparam int               HOLDOFF_CYCLES = 80;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [SIZE_W-1:0] data_size;
        logic [IDX_W-1:0]  block_index;
    } t_request;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  block_index;
        logic [SIZE_W-1:0] data_size;
        logic [QCNT_W-1:0] queue_count;
    } t_pool_result;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    bpq_in_if  in_ch ();
    bpq_out_if out_ch ();

    block_pool_queue_manager_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Pool model: registers, free list, ready queue and per-block flags
    logic [SIZE_W-1:0] pool_max_size;
    logic [BCNT_W-1:0] pool_blk_count;
    logic [IDX_W-1:0]  free_list[$];
    logic [IDX_W-1:0]  ready_list[$];
    logic              blk_valid   [NUM_BLOCKS];
    logic [SIZE_W-1:0] blk_size    [NUM_BLOCKS];
    logic              blk_pending [NUM_BLOCKS];

    t_request     req_q[$];
    t_pool_result awaited_results[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int holdoff_reqs  = 0;
    int holdoff_seen  = 0;
    int hold_left     = 0;
    int n_requests    = 0;
    int n_errors      = 0;
    int status_hits [8];

    always #(HALF_PERIOD) i_clk = ~i_clk;

    initial begin : watchdog
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("%0t: timeout, %0d results still awaited", $time, awaited_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // Blocks in use: the register value clamped to the pool size
    function automatic int pool_limit();
        return (pool_blk_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(pool_blk_count);
    endfunction

    function automatic void pool_refill();
        free_list.delete();
        ready_list.delete();
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            blk_valid[i]   = 1'b0;
            blk_size[i]    = '0;
            blk_pending[i] = 1'b0;
        end
        for (int i = 0; i < pool_limit(); i++) free_list.insert(free_list.size(), IDX_W'(i));
    endfunction

    function automatic void blk_release(logic [IDX_W-1:0] b);
        blk_valid[b]   = 1'b0;
        blk_size[b]    = '0;
        blk_pending[b] = 1'b0;
        if (free_list.size() < NUM_BLOCKS) free_list.insert(free_list.size(), b);
    endfunction

    // Apply one request to the pool and return the result beat it must produce
    function automatic t_pool_result pool_apply(t_request rq);
        t_pool_result r;
        logic [IDX_W-1:0] b;
        r = '{ST_OK, '0, '0, '0};
        case (rq.cmd)
            CMD_ADD: begin
                if (rq.data_size == 0 || rq.data_size > pool_max_size) begin
                    r.status = ST_BAD_SIZE;
                end else if (free_list.size() == 0) begin
                    r.status = ST_FULL;
                end else begin
                    b = free_list[0];
                    free_list.delete(0);
                    blk_valid[b] = 1'b1;
                    blk_size[b]  = rq.data_size;
                    if (ready_list.size() < NUM_BLOCKS) ready_list.insert(ready_list.size(), b);
                    r.block_index = b;
                end
            end
            CMD_GET: begin
                if (ready_list.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    b = ready_list[0];
                    ready_list.delete(0);
                    r.block_index = b;
                    if (blk_valid[b] && blk_size[b] != 0) begin
                        r.data_size    = blk_size[b];
                        blk_pending[b] = 1'b1;
                    end else begin
                        blk_release(b);
                        r.status = ST_BAD_BLOCK;
                    end
                end
            end
            CMD_FREE: begin
                if (int'(rq.block_index) >= pool_limit()) begin
                    r.status = ST_INDEX_OUT;
                end else if (!blk_pending[rq.block_index]) begin
                    r.status = ST_NOT_PENDING;
                end else begin
                    blk_release(rq.block_index);
                end
            end
            default: ;
        endcase
        r.queue_count = (ready_list.size() > QCNT_MAX) ? QCNT_W'(QCNT_MAX)
                                                       : QCNT_W'(ready_list.size());
        return r;
    endfunction

    // Random pending block, or -1 when nothing is handed out
    function automatic int pick_pending();
        int start;
        int j;
        start = $urandom_range(NUM_BLOCKS - 1);
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            j = (start + i) % NUM_BLOCKS;
            if (blk_pending[j]) return j;
        end
        return -1;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8) return '0;
        if (roll < 16) begin
            if (pool_max_size == '1) return '1;
            return SIZE_W'($urandom_range(65535, int'(pool_max_size) + 1));
        end
        if (roll < 24) return SIZE_W'($urandom);
        if (roll < 30) return pool_max_size;
        if (pool_max_size == 0) return SIZE_W'(1);
        return SIZE_W'($urandom_range(int'(pool_max_size), 1));
    endfunction

    // Mostly well-formed traffic: frees aim at blocks that are handed out
    function automatic t_request pick_request(int add_pct);
        t_request rq;
        int roll;
        int p;
        roll           = $urandom_range(99);
        rq.data_size   = SIZE_W'($urandom);
        rq.block_index = IDX_W'($urandom);
        if (roll < add_pct) begin
            rq.cmd       = CMD_ADD;
            rq.data_size = pick_size();
        end else if (roll < add_pct + (100 - add_pct) / 2) begin
            rq.cmd = CMD_GET;
        end else if (roll < 97) begin
            rq.cmd = CMD_FREE;
            p = pick_pending();
            if (p >= 0 && $urandom_range(9) < 8) rq.block_index = IDX_W'(p);
        end else begin
            rq.cmd = CMD_UNUSED;
        end
        return rq;
    endfunction

    function automatic void check_field(string field, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
            n_errors++;
        end
    endfunction

    // Request driver: predict on each accepted beat, then offer the next one or idle
    always @(posedge i_clk) begin : drive_requests
        t_request rq;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                rq = '{in_ch.cmd, in_ch.data_size, in_ch.block_index};
                awaited_results.insert(awaited_results.size(), pool_apply(rq));
                n_requests++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    rq = req_q[0];
                    req_q.delete(0);
                    in_ch.valid       <= 1'b1;
                    in_ch.cmd         <= rq.cmd;
                    in_ch.data_size   <= rq.data_size;
                    in_ch.block_index <= rq.block_index;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each beat with the oldest prediction, drive ready
    always @(posedge i_clk) begin : check_results
        t_pool_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result beat, status %0d index %0d", $time,
                             out_ch.status, out_ch.out_block_index);
                    n_errors++;
                end else begin
                    want = awaited_results[0];
                    awaited_results.delete(0);
                    check_field("status", want.status, out_ch.status);
                    check_field("out_block_index", want.block_index, out_ch.out_block_index);
                    check_field("out_data_size", want.data_size, out_ch.out_data_size);
                    check_field("queue_count", want.queue_count, out_ch.queue_count);
                    status_hits[want.status]++;
                end
            end
            // Long hold-off on request, otherwise random stalls
            if (holdoff_reqs != holdoff_seen) begin
                holdoff_seen = holdoff_reqs;
                hold_left    = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic queue_req(logic [CMD_W-1:0] cmd, int size, int idx);
        req_q.insert(req_q.size(), t_request'{cmd, SIZE_W'(size), IDX_W'(idx)});
    endtask

    // Wait until every request is sent and every result has come back
    task automatic drain();
        do @(negedge i_clk);
        while (req_q.size() != 0 || in_ch.valid || awaited_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MAX_SIZE) begin
            pool_max_size = SIZE_W'(data);
        end else begin
            pool_blk_count = BCNT_W'(data);
            pool_refill();
        end
    endtask

    task automatic run_phase(int n, int idle, int stall, int add_pct, bit hold);
        send_idle_pct = idle;
        stall_pct     = stall;
        if (hold) holdoff_reqs++;
        for (int k = 0; k < n; k++) begin
            while (req_q.size() >= 2) @(negedge i_clk);
            req_q.insert(req_q.size(), pick_request(add_pct));
        end
        drain();
    endtask

    initial begin : stimulus
        in_ch.valid       = 1'b0;
        in_ch.cmd         = CMD_ADD;
        in_ch.data_size   = '0;
        in_ch.block_index = '0;
        out_ch.ready      = 1'b0;
        for (int i = 0; i < 8; i++) status_hits[i] = 0;
        pool_max_size  = MAX_SIZE_RST;
        pool_blk_count = BCNT_RST;
        pool_refill();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: ops on an empty ready queue, size limits, unused command, round trip
        queue_req(CMD_GET, 0, 0);
        queue_req(CMD_FREE, 0, 0);
        queue_req(CMD_ADD, 0, 0);
        queue_req(CMD_ADD, 4097, 0);
        queue_req(CMD_ADD, 4096, 0);
        queue_req(CMD_ADD, 1, 0);
        queue_req(CMD_UNUSED, 16'hFFFF, 8'hFF);
        queue_req(CMD_GET, 0, 0);
        queue_req(CMD_FREE, 0, 255);
        queue_req(CMD_FREE, 0, 0);
        queue_req(CMD_FREE, 0, 0);
        drain();

        // Two-block pool: full pool and index bound
        cfg_write(CFG_MAX_SIZE, 65535);
        cfg_write(CFG_BLK_COUNT, 2);
        queue_req(CMD_ADD, 65535, 0);
        queue_req(CMD_ADD, 16'hAAAA, 0);
        queue_req(CMD_ADD, 16'h5555, 0);
        queue_req(CMD_FREE, 0, 2);
        queue_req(CMD_GET, 0, 0);
        queue_req(CMD_GET, 0, 0);
        queue_req(CMD_GET, 0, 0);
        queue_req(CMD_FREE, 0, 1);
        drain();

        // Empty pool, zero size limit, block count above the pool size
        cfg_write(CFG_BLK_COUNT, 0);
        queue_req(CMD_ADD, 7, 0);
        queue_req(CMD_FREE, 0, 0);
        drain();
        cfg_write(CFG_MAX_SIZE, 0);
        queue_req(CMD_ADD, 1, 0);
        drain();
        cfg_write(CFG_BLK_COUNT, 300);
        queue_req(CMD_FREE, 0, 255);
        drain();

        // Random phases over several pool settings and idling patterns
        cfg_write(CFG_MAX_SIZE, 4096);
        cfg_write(CFG_BLK_COUNT, 256);
        run_phase(300, 0, 0, 45, 1'b1);
        cfg_write(CFG_MAX_SIZE, 65535);
        cfg_write(CFG_BLK_COUNT, 16);
        run_phase(300, 74, 0, 50, 1'b0);
        cfg_write(CFG_MAX_SIZE, 1);
        cfg_write(CFG_BLK_COUNT, 4);
        run_phase(250, 0, 74, 55, 1'b0);
        cfg_write(CFG_MAX_SIZE, 1000);
        cfg_write(CFG_BLK_COUNT, 256);
        run_phase(300, 18, 18, 45, 1'b1);
        cfg_write(CFG_MAX_SIZE, 65535);
        cfg_write(CFG_BLK_COUNT, 1);
        run_phase(200, 0, 0, 50, 1'b0);
        cfg_write(CFG_MAX_SIZE, 300);
        cfg_write(CFG_BLK_COUNT, 64);
        run_phase(200, 18, 18, 40, 1'b0);

        repeat (10) @(negedge i_clk);
        $display("Checked %0d requests across pool sizes 0 to 256: ok %0d, bad size %0d",
                 n_requests, status_hits[ST_OK], status_hits[ST_BAD_SIZE]);
        $display("full %0d, empty %0d, index out %0d, not pending %0d, bad block %0d; %0d mismatches",
                 status_hits[ST_FULL], status_hits[ST_EMPTY], status_hits[ST_INDEX_OUT],
                 status_hits[ST_NOT_PENDING], status_hits[ST_BAD_BLOCK], n_errors);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/bpq_pkg.sv
rtl/core/bpq_in_if.sv
rtl/core/bpq_out_if.sv
rtl/core/bpq_ram.sv
rtl/core/bpq_ctrl.sv
rtl/core/bpq_dp.sv
rtl/core/block_pool_queue_manager_unit.sv
rtl/core/bpq_checker.sv
tb/sv/block_pool_queue_manager_unit_tb.sv
